/* sv/png_stored_stream_encoder_assert.svh */
// Assertion macros for the encoder checker
`ifndef PNG_STORED_STREAM_ENCODER_ASSERT_SVH
`define PNG_STORED_STREAM_ENCODER_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define PSE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define PSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* sv/pse_pkg.sv */
// Package for the PNG stored-stream encoder: types, constants, CRC function
`default_nettype none
package pse_pkg;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic        OP_START = 1'b0;
    localparam logic        OP_PIXEL = 1'b1;

    // Byte kinds coming out of the front sequencer
    typedef enum logic [2:0] {
        K_PLAIN,     // byte as given, no CRC
        K_CRC,       // byte folded into CRC
        K_RAW,       // image byte: CRC and Adler
        K_CRC_OUT,   // CRC byte number sel, then restart CRC on last
        K_ADLER      // Adler byte number sel, with CRC
    } kind_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic [1:0] sel;
        logic       crc_init;
        logic       run_last;
        logic       frame_done;
    } tok_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_HEAD,
        F_PIX,
        F_TAIL
    } fstate_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        return c;
    endfunction
endpackage
`default_nettype wire

/* sv/pse_queue.sv */
// Small FIFO of byte tokens between the front sequencer and the back end
`default_nettype none
module pse_queue
    import pse_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  tok_t      push_tok,
    output logic      full,
    input  wire logic pop,
    output tok_t      pop_tok,
    output logic      empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    tok_t           mem_reg [DEPTH];
    logic [AW-1:0]  wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]    cnt_reg, cnt_next;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_tok = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) cnt_next = cnt_reg + 1'b1;
        else if (pop && !push) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= push_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

/* sv/pse_back.sv */
// Back end: running CRC-32 and Adler-32, output register
`default_nettype none
module pse_back
    import pse_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       empty,
    input  tok_t            tok,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            frame_done
);
    logic [31:0] crc_reg, crc_next;
    logic [15:0] alo_reg, alo_next, ahi_reg, ahi_next;
    logic        v_reg;
    logic [7:0]  b_reg;
    logic        rl_reg, fd_reg;
    logic [7:0]  b_next;
    logic [31:0] crc_x;
    logic [31:0] adl;
    logic [16:0] s_lo, s_hi;

    assign pop = !empty && (!v_reg || !out_stall);

    always_comb
    begin
        crc_x = ~crc_reg;
        adl   = {ahi_reg, alo_reg};
        unique case (tok.sel)
            2'd0: b_next = (tok.kind == K_ADLER) ? adl[31:24] : crc_x[31:24];
            2'd1: b_next = (tok.kind == K_ADLER) ? adl[23:16] : crc_x[23:16];
            2'd2: b_next = (tok.kind == K_ADLER) ? adl[15:8]  : crc_x[15:8];
            default: b_next = (tok.kind == K_ADLER) ? adl[7:0] : crc_x[7:0];
        endcase
        if (tok.kind != K_ADLER && tok.kind != K_CRC_OUT) b_next = tok.data;

        crc_next = crc_reg;
        alo_next = alo_reg;
        ahi_next = ahi_reg;
        s_lo = '0;
        s_hi = '0;
        unique case (tok.kind)
            K_PLAIN: ;
            K_CRC, K_ADLER: crc_next = crc_byte(crc_reg, b_next);
            K_RAW:
            begin
                crc_next = crc_byte(crc_reg, b_next);
                s_lo = {1'b0, alo_reg} + {9'd0, b_next};
                if (s_lo >= ADLER_MOD) s_lo = s_lo - ADLER_MOD;
                s_hi = {1'b0, ahi_reg} + s_lo;
                if (s_hi >= ADLER_MOD) s_hi = s_hi - ADLER_MOD;
                alo_next = s_lo[15:0];
                ahi_next = s_hi[15:0];
            end
            K_CRC_OUT: if (tok.sel == 2'd3) crc_next = '1;
            default: ;
        endcase
        if (tok.crc_init)
        begin
            // restart chunk and checksum state at frame start
            crc_next = '1;
            alo_next = 16'd1;
            ahi_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= '1;
            alo_reg <= 16'd1;
            ahi_reg <= '0;
            v_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                crc_reg <= crc_next;
                alo_reg <= alo_next;
                ahi_reg <= ahi_next;
                v_reg   <= 1'b1;
            end
            else if (!out_stall)
            begin
                v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_reg  <= b_next;
            rl_reg <= tok.run_last;
            fd_reg <= tok.frame_done;
        end
    end

    assign out_valid  = v_reg;
    assign out_byte   = b_reg;
    assign run_last   = rl_reg;
    assign frame_done = fd_reg;
endmodule
`default_nettype wire

/* sv/pse_front.sv */
// Front sequencer: accepts items, expands them into byte tokens
`default_nettype none
module pse_front
    import pse_pkg::*;
#(
    parameter int MAX_DIM   = 8192,
    parameter int BLOCK_MAX = 65535
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [13:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    output logic             push,
    output tok_t             tok,
    input  wire logic        full
);
    localparam logic [16:0] BS = (BLOCK_MAX < 2) ? 17'd2 :
                                 (BLOCK_MAX > 65535) ? 17'd65535 : 17'(BLOCK_MAX);
    localparam logic [13:0] MD = 14'(MAX_DIM);
    localparam int HEAD_N = 43;
    localparam int TAIL_N = 20;
    // block count by reciprocal: floor(x / BS) = (x * NB_M) >> NB_S for x below 2^29
    localparam int NB_N = 29;
    localparam int NB_L = $clog2(BS);
    localparam int NB_S = NB_N + NB_L;
    localparam logic [29:0] NB_M = 30'(((64'd1 << NB_S) + 64'(BS) - 64'd1) / 64'(BS));

    fstate_t     st_reg, st_next;
    logic [13:0] wcfg_reg, hcfg_reg;
    logic [13:0] fw_reg, fh_reg;
    logic [12:0] col_reg, row_reg;
    logic [16:0] blk_reg;
    logic [27:0] raw_reg;
    logic        open_reg;
    logic [5:0]  idx_reg;
    logic [2:0]  pos_reg;
    logic [2:0]  hdr_reg;
    logic [7:0]  r_reg, g_reg, b_reg;
    logic        fin_reg;
    logic [31:0] len_reg;
    logic [1:0]  lphase_reg;
    logic [27:0] p1_reg;
    logic [27:0] nb_reg;
    logic [28:0] nb_num;
    logic [58:0] nb_prod;
    logic [16:0] n_now;
    logic [15:0] ninv;
    logic [7:0]  raw_byte;
    logic        at_last_raw;
    logic        last_pix_byte;
    logic [13:0] wc, hc;

    function automatic logic [13:0] clamp(input logic [13:0] v);
        if (v == '0) return 14'd1;
        if (v > MD) return MD;
        return v;
    endfunction

    assign wc = clamp(wcfg_reg);
    assign hc = clamp(hcfg_reg);

    // accept only when idle with no length work left
    assign in_stall = (st_reg != F_IDLE) || (lphase_reg != 2'd0);

    assign n_now = (raw_reg < {11'd0, BS}) ? raw_reg[16:0] : BS;
    assign ninv  = ~n_now[15:0];

    assign nb_num  = {1'b0, raw_reg} + 29'(BS) - 29'd1;
    assign nb_prod = 59'(nb_num) * 59'(NB_M);

    always_comb
    begin
        unique case (pos_reg)
            3'd0: raw_byte = 8'd0;
            3'd1: raw_byte = r_reg;
            3'd2: raw_byte = g_reg;
            default: raw_byte = b_reg;
        endcase
    end

    assign at_last_raw   = (pos_reg == 3'd3) && (hdr_reg == 3'd5);
    assign last_pix_byte = at_last_raw && !fin_reg;

    function automatic logic [7:0] head_byte(input logic [5:0] i, input logic [13:0] w,
                                             input logic [13:0] h, input logic [31:0] l);
        unique case (i)
            6'd0: return 8'h89; 6'd1: return 8'h50; 6'd2: return 8'h4E; 6'd3: return 8'h47;
            6'd4: return 8'h0D; 6'd5: return 8'h0A; 6'd6: return 8'h1A; 6'd7: return 8'h0A;
            6'd8, 6'd9, 6'd10: return 8'h00; 6'd11: return 8'd13;
            6'd12: return 8'h49; 6'd13: return 8'h48; 6'd14: return 8'h44; 6'd15: return 8'h52;
            6'd16, 6'd17: return 8'h00; 6'd18: return {2'b00, w[13:8]}; 6'd19: return w[7:0];
            6'd20, 6'd21: return 8'h00; 6'd22: return {2'b00, h[13:8]}; 6'd23: return h[7:0];
            6'd24: return 8'd8; 6'd25: return 8'd2;
            6'd30: return l[31:24]; 6'd31: return l[23:16];
            6'd32: return l[15:8];  6'd33: return l[7:0];
            6'd34: return 8'h49; 6'd35: return 8'h44; 6'd36: return 8'h41; 6'd37: return 8'h54;
            6'd38: return 8'h78; 6'd39: return 8'h01;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] tail_byte(input logic [5:0] i);
        unique case (i)
            6'd12: return 8'h49; 6'd13: return 8'h45; 6'd14: return 8'h4E; 6'd15: return 8'h44;
            default: return 8'h00;
        endcase
    endfunction

    always_comb
    begin
        push    = 1'b0;
        tok     = '0;
        st_next = st_reg;
        unique case (st_reg)
            F_IDLE:
            begin
                if (lphase_reg == 2'd3) st_next = F_HEAD;
                else if (in_valid && !in_stall && op == OP_PIXEL && open_reg) st_next = F_PIX;
            end
            F_HEAD:
            begin
                push         = !full;
                tok.crc_init = (idx_reg == 6'd0);
                if (idx_reg >= 6'd29 && idx_reg <= 6'd32)
                begin
                    // IHDR CRC, most significant byte first
                    tok.kind = K_CRC_OUT;
                    tok.sel  = 2'(idx_reg - 6'd29);
                end
                else
                begin
                    tok.kind = ((idx_reg >= 6'd12 && idx_reg <= 6'd28) || idx_reg >= 6'd37) ?
                               K_CRC : K_PLAIN;
                    tok.data = head_byte((idx_reg >= 6'd33) ? idx_reg - 6'd3 : idx_reg,
                                         fw_reg, fh_reg, len_reg);
                end
                tok.run_last = (idx_reg == 6'(HEAD_N - 1));
                if (!full && idx_reg == 6'(HEAD_N - 1)) st_next = F_IDLE;
            end
            F_PIX:
            begin
                push = !full;
                if (hdr_reg != 3'd5)
                begin
                    tok.kind = K_CRC;
                    unique case (hdr_reg)
                        3'd0: tok.data = {7'd0, raw_reg == {11'd0, n_now}};
                        3'd1: tok.data = n_now[7:0];
                        3'd2: tok.data = {n_now[15:8]};
                        3'd3: tok.data = ninv[7:0];
                        default: tok.data = ninv[15:8];
                    endcase
                end
                else
                begin
                    tok.kind     = K_RAW;
                    tok.data     = raw_byte;
                    tok.run_last = last_pix_byte;
                end
                if (!full && at_last_raw) st_next = fin_reg ? F_TAIL : F_IDLE;
            end
            F_TAIL:
            begin
                push = !full;
                if (idx_reg < 6'd4)
                begin
                    tok.kind = K_ADLER;
                    tok.sel  = idx_reg[1:0];
                end
                else if (idx_reg < 6'd8)
                begin
                    tok.kind = K_CRC_OUT;
                    tok.sel  = 2'(idx_reg - 6'd4);
                end
                else if (idx_reg < 6'd12) tok.kind = K_PLAIN;
                else if (idx_reg < 6'd16)
                begin
                    tok.kind = K_CRC;
                    tok.data = tail_byte(idx_reg);
                end
                else
                begin
                    tok.kind = K_CRC_OUT;
                    tok.sel  = 2'(idx_reg - 6'd16);
                end
                tok.run_last   = (idx_reg == 6'(TAIL_N - 1));
                tok.frame_done = tok.run_last;
                if (!full && idx_reg == 6'(TAIL_N - 1)) st_next = F_IDLE;
            end
            default: st_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= F_IDLE;
            wcfg_reg   <= 14'd160;
            hcfg_reg   <= 14'd144;
            open_reg   <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
            blk_reg    <= '0;
            raw_reg    <= '0;
            idx_reg    <= '0;
            pos_reg    <= '0;
            hdr_reg    <= 3'd5;
            fin_reg    <= 1'b0;
            lphase_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we)
            begin
                if (cfg_index == 1'b0) wcfg_reg <= cfg_data;
                else                   hcfg_reg <= cfg_data;
            end
            // length pipeline: raw size, block count, IDAT length
            unique case (lphase_reg)
                2'd1:
                begin
                    raw_reg    <= 28'(p1_reg * 28'(fh_reg));
                    lphase_reg <= 2'd2;
                end
                2'd2:
                begin
                    nb_reg     <= 28'(nb_prod >> NB_S);
                    lphase_reg <= 2'd3;
                end
                2'd3:
                begin
                    len_reg    <= 32'(nb_reg) * 32'd5 + 32'(raw_reg) + 32'd6;
                    lphase_reg <= 2'd0;
                    idx_reg    <= '0;
                end
                default: ;
            endcase
            if (in_valid && !in_stall)
            begin
                if (op == OP_START)
                begin
                    fw_reg     <= wc;
                    fh_reg     <= hc;
                    p1_reg     <= 28'd1 + 28'd3 * 28'(wc);
                    lphase_reg <= 2'd1;
                    open_reg   <= 1'b1;
                    col_reg    <= '0;
                    row_reg    <= '0;
                    blk_reg    <= '0;
                    hdr_reg    <= 3'd5;
                end
                else if (open_reg)
                begin
                    r_reg   <= red;
                    g_reg   <= green;
                    b_reg   <= blue;
                    pos_reg <= (col_reg == '0) ? 3'd0 : 3'd1;
                    hdr_reg <= ((blk_reg == '0) && (raw_reg != '0)) ? 3'd0 : 3'd5;
                    if (14'(col_reg) + 14'd1 >= fw_reg)
                    begin
                        col_reg <= '0;
                        if (14'(row_reg) + 14'd1 >= fh_reg)
                        begin
                            row_reg  <= '0;
                            fin_reg  <= 1'b1;
                            open_reg <= 1'b0;
                        end
                        else
                        begin
                            row_reg <= row_reg + 1'b1;
                            fin_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                        fin_reg <= 1'b0;
                    end
                end
            end
            if (st_reg == F_HEAD && !full) idx_reg <= idx_reg + 1'b1;
            if (st_reg == F_TAIL && !full)
            begin
                idx_reg <= (idx_reg == 6'(TAIL_N - 1)) ? '0 : idx_reg + 1'b1;
            end
            if (st_reg == F_PIX && !full)
            begin
                if (hdr_reg != 3'd5)
                begin
                    if (hdr_reg == 3'd4) blk_reg <= n_now;
                    hdr_reg <= hdr_reg + 1'b1;
                end
                else
                begin
                    blk_reg <= blk_reg - 1'b1;
                    raw_reg <= raw_reg - 1'b1;
                    pos_reg <= pos_reg + 1'b1;
                    hdr_reg <= ((blk_reg == 17'd1) && (raw_reg != 28'd1)) ? 3'd0 : 3'd5;
                    if (at_last_raw && fin_reg) idx_reg <= '0;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* sv/png_stored_stream_encoder.sv */
// Top level of the PNG stored-stream encoder: front, token queue, back end
// A start item (op 0) holds the input through the setup steps (frame size product,
// stored-block count by reciprocal multiplication, IDAT length), then while 43 header bytes
// go out at one byte per cycle unless the queue is full. A pixel holds the input while
// it emits its bytes: 3 bytes, 4 at the start of a row, 5 more where a stored-block header
// falls and 20 trailer bytes on the last pixel. The output
// port moves at most one byte per cycle; a 4-deep queue of byte tokens lets the front and
// the output stall apart, and output stalls reach the input once the queue fills.
`default_nettype none
module png_stored_stream_encoder
    import pse_pkg::*;
#(
    parameter int MAX_DIM   = 8192,
    parameter int BLOCK_MAX = 65535
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [13:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             frame_done
);
    logic push, pop, full, empty;
    tok_t push_tok, pop_tok;

    pse_front #(.MAX_DIM(MAX_DIM), .BLOCK_MAX(BLOCK_MAX)) u_front (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_stall,
        .op, .red, .green, .blue, .push, .tok(push_tok), .full
    );

    pse_queue #(.DEPTH(4)) u_queue (
        .clk, .rst_n, .push, .push_tok, .full, .pop, .pop_tok, .empty
    );

    pse_back u_back (
        .clk, .rst_n, .empty, .tok(pop_tok), .pop, .out_valid, .out_stall,
        .out_byte, .run_last, .frame_done
    );
endmodule
`default_nettype wire

/* sv/pse_checker.sv */
// Port checker for the PNG stored-stream encoder, bound to the top level
`default_nettype none
`include "png_stored_stream_encoder_assert.svh"
module pse_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       run_last,
    input wire logic       frame_done
);
    // frame end is always the end of an item's run
    `PSE_ASSERT_IMPL(a_done_last, out_valid && frame_done, run_last, "frame_done without run_last")
    // last IEND byte is the final CRC byte 0x82
    `PSE_ASSERT_IMPL(a_done_byte, out_valid && frame_done, out_byte == 8'h82, "bad IEND CRC")
    // stalled beat holds
    `PSE_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_byte), "beat dropped")
endmodule
bind png_stored_stream_encoder pse_checker u_pse_checker (
    .clk, .rst_n, .out_valid, .out_stall, .out_byte, .run_last, .frame_done
);
`default_nettype wire
